// File: rtl/core/olpe_pkg.sv
// shared types and constants for the ordered list positional edit core
`default_nettype none
package olpe_pkg;

   localparam int CAPACITY = 16;
   localparam int VAL_W    = 32;
   localparam int POS_W    = 8;
   localparam int CMD_W    = 3;
   localparam int STS_W    = 2;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   // wide enough for position and count + 1 without wrap
   localparam int CMP_W    = ((CNT_W + 1) > (POS_W + 1)) ? (CNT_W + 1) : (POS_W + 1);
   localparam int REQ_DATA_W = ((VAL_W + POS_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_BACK  = 3'd1,
      CMD_INS_POS   = 3'd2,
      CMD_DEL_FRONT = 3'd3,
      CMD_DEL_BACK  = 3'd4,
      CMD_DEL_POS   = 3'd5,
      CMD_READ      = 3'd6
   } cmd_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_RANGE = 2'd2,
      STS_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic latch;        // capture the accepted request
      logic load_status;  // emit the status result of the held command
      logic apply_edit;   // perform the held edit on the list
      logic load_item;    // emit the list entry at the read index
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic             valid_cmd;
      logic             is_read;
      logic             empty;
      logic             rd_last;
      logic [CNT_W-1:0] count;
   } dp_sts_type;

endpackage
`default_nettype wire

// File: rtl/core/ordered_list_positional_edit_core.sv
// Ordered list of up to CAPACITY signed 32-bit values with positional edits.
// The req channel carries one command per transfer: tuser holds the command
// (insert front/back/position, delete front/back/position, read out), tdata
// the value to insert and the 1-based position. The rsp channel returns one
// status transfer per edit (tlast set), or for a read every stored value
// from front to back with tlast on the final one; a read of an empty list
// gives a single empty-status transfer. Unused command code 7 gives nothing.
// A command is taken in the idle state and executed in the execute state;
// the status lands in the result register at the end of the execute step,
// which sets the registered rsp_tvalid. No new command is taken before the
// held one has executed. A read loads its values from the read state and
// streams one value per cycle while the result register is free, so the
// next command is taken only after the last value of the read is loaded.
// A new command can be taken while an earlier result still waits in the
// result register; execution then stalls until that result is taken, so a
// stalled receiver holds the current result and back-pressures req.
// Reset empties the list and clears all handshake state.
`default_nettype none
module ordered_list_positional_edit_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // value [31:0], position [39:32]
   input  wire logic [olpe_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command [2:0]
   input  wire logic [olpe_pkg::CMD_W-1:0]        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // item_value [31:0]
   output logic [olpe_pkg::VAL_W-1:0]             rsp_tdata,
   // status [1:0]
   output logic [olpe_pkg::STS_W-1:0]             rsp_tuser,
   output logic                                   rsp_tlast
);

   olpe_pkg::ctrl_cmd_type cmd;
   olpe_pkg::dp_sts_type   sts;

   olpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   olpe_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      sts.count <= olpe_pkg::CNT_W'(olpe_pkg::CAPACITY))
      else $error("list count above capacity");

   a_item_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |-> !sts.empty)
      else $error("read-out entry emitted from an empty list");

   a_single_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_status && cmd.load_item))
      else $error("two results loaded in one cycle");

   a_accept_no_load: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !(cmd.load_status || cmd.load_item || cmd.apply_edit))
      else $error("result or edit in the cycle a command is taken");

   a_edit_valid_next: assert property (@(posedge clock) disable iff (reset)
      cmd.apply_edit |=> rsp_tvalid && rsp_tlast)
      else $error("edit without a final status result");
`endif

endmodule
`default_nettype wire

// File: rtl/core/olpe_dpath.sv
// datapath: command register, shifting cell chain, count, read index and result register
`default_nettype none
module olpe_dpath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [olpe_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic [olpe_pkg::CMD_W-1:0]           req_tuser,
   input  wire olpe_pkg::ctrl_cmd_type               cmd,
   output olpe_pkg::dp_sts_type                      sts,
   output logic [olpe_pkg::VAL_W-1:0]                rsp_tdata,
   output logic [olpe_pkg::STS_W-1:0]                rsp_tuser,
   output logic                                      rsp_tlast
);

   logic [olpe_pkg::CMD_W-1:0] cmd_ff;
   logic [olpe_pkg::VAL_W-1:0] val_ff;
   logic [olpe_pkg::POS_W-1:0] pos_ff;

   logic [olpe_pkg::VAL_W-1:0] cell_ff [olpe_pkg::CAPACITY];
   logic [olpe_pkg::VAL_W-1:0] cell_in [olpe_pkg::CAPACITY];
   logic [olpe_pkg::CNT_W-1:0] count_ff, count_in;
   logic [olpe_pkg::IDX_W-1:0] rd_idx_ff, rd_idx_in;

   logic [olpe_pkg::VAL_W-1:0] rsp_data_ff, rsp_data_in;
   logic [olpe_pkg::STS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                       rsp_last_ff, rsp_last_in;

   olpe_pkg::status_type       status;
   logic                       is_ins;
   logic                       is_del;
   logic                       edit_ok;
   logic [olpe_pkg::CMP_W-1:0] cnt_ext;
   logic [olpe_pkg::CMP_W-1:0] pos_ext;
   logic [olpe_pkg::CMP_W-1:0] slot_wide;
   logic [olpe_pkg::IDX_W-1:0] slot;

   assign cnt_ext = olpe_pkg::CMP_W'(count_ff);
   assign pos_ext = olpe_pkg::CMP_W'(pos_ff);

   // status and target slot of the held command
   always_comb begin
      status    = olpe_pkg::STS_OK;
      is_ins    = 1'b0;
      is_del    = 1'b0;
      slot_wide = '0;
      case (olpe_pkg::cmd_type'(cmd_ff)) inside
         olpe_pkg::CMD_INS_FRONT, olpe_pkg::CMD_INS_BACK, olpe_pkg::CMD_INS_POS: begin
            is_ins = 1'b1;
            if (cmd_ff == olpe_pkg::CMD_INS_FRONT) begin
               slot_wide = '0;
            end else if (cmd_ff == olpe_pkg::CMD_INS_BACK) begin
               slot_wide = cnt_ext;
            end else begin
               slot_wide = pos_ext - olpe_pkg::CMP_W'(1);
            end
            if (count_ff >= olpe_pkg::CNT_W'(olpe_pkg::CAPACITY)) begin
               status = olpe_pkg::STS_FULL;
            end else if ((cmd_ff == olpe_pkg::CMD_INS_POS) &&
                         ((pos_ext == '0) || (pos_ext > cnt_ext + olpe_pkg::CMP_W'(1)))) begin
               status = olpe_pkg::STS_RANGE;
            end
         end
         olpe_pkg::CMD_DEL_FRONT, olpe_pkg::CMD_DEL_BACK, olpe_pkg::CMD_DEL_POS: begin
            is_del = 1'b1;
            if (cmd_ff == olpe_pkg::CMD_DEL_FRONT) begin
               slot_wide = '0;
            end else if (cmd_ff == olpe_pkg::CMD_DEL_BACK) begin
               slot_wide = cnt_ext - olpe_pkg::CMP_W'(1);
            end else begin
               slot_wide = pos_ext - olpe_pkg::CMP_W'(1);
            end
            if (count_ff == '0) begin
               status = olpe_pkg::STS_EMPTY;
            end else if ((cmd_ff == olpe_pkg::CMD_DEL_POS) &&
                         ((pos_ext == '0) || (pos_ext > cnt_ext))) begin
               status = olpe_pkg::STS_RANGE;
            end
         end
         olpe_pkg::CMD_READ: begin
            if (count_ff == '0) begin
               status = olpe_pkg::STS_EMPTY;
            end
         end
         default: begin
            status = olpe_pkg::STS_OK;
         end
      endcase
   end

   assign slot    = slot_wide[olpe_pkg::IDX_W-1:0];
   assign edit_ok = cmd.apply_edit && (status == olpe_pkg::STS_OK);

   // each cell holds, loads the new value or takes a neighbor
   always_comb begin
      for (int i = 0; i < olpe_pkg::CAPACITY; i++) begin
         cell_in[i] = cell_ff[i];
         if (edit_ok && is_ins) begin
            if (i == int'(slot)) begin
               cell_in[i] = val_ff;
            end else if (i > int'(slot)) begin
               cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (edit_ok && is_del) begin
            if ((i >= int'(slot)) && (i < olpe_pkg::CAPACITY - 1)) begin
               cell_in[i] = cell_ff[(i < olpe_pkg::CAPACITY - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (edit_ok && is_ins) begin
         count_in = count_ff + olpe_pkg::CNT_W'(1);
      end else if (edit_ok && is_del) begin
         count_in = count_ff - olpe_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (cmd.latch) begin
         rd_idx_in = '0;
      end else if (cmd.load_item) begin
         rd_idx_in = rd_idx_ff + olpe_pkg::IDX_W'(1);
      end
   end

   always_comb begin
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.load_status) begin
         rsp_data_in   = '0;
         rsp_status_in = status;
         rsp_last_in   = 1'b1;
      end else if (cmd.load_item) begin
         rsp_data_in   = cell_ff[rd_idx_ff];
         rsp_status_in = olpe_pkg::STS_OK;
         rsp_last_in   = sts.rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_idx_ff <= '0;
      end else begin
         count_ff  <= count_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff <= req_tuser;
         val_ff <= req_tdata[olpe_pkg::VAL_W-1:0];
         pos_ff <= req_tdata[olpe_pkg::VAL_W +: olpe_pkg::POS_W];
      end
      for (int i = 0; i < olpe_pkg::CAPACITY; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign sts.valid_cmd = (cmd_ff <= olpe_pkg::CMD_READ);
   assign sts.is_read   = (cmd_ff == olpe_pkg::CMD_READ);
   assign sts.empty     = (count_ff == '0);
   assign sts.rd_last   = (olpe_pkg::CNT_W'(rd_idx_ff) == count_ff - olpe_pkg::CNT_W'(1));
   assign sts.count     = count_ff;

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_status_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule
`default_nettype wire

// File: rtl/core/olpe_ctrl.sv
// controller: accept, execute and read-out sequencing plus result valid flag
`default_nettype none
module olpe_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire olpe_pkg::dp_sts_type    sts,
   output olpe_pkg::ctrl_cmd_type       cmd
);

   olpe_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   // result register is free or drains this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         olpe_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = olpe_pkg::ST_EXEC;
            end
         end
         olpe_pkg::ST_EXEC: begin
            if (!sts.valid_cmd) begin
               state_in = olpe_pkg::ST_IDLE;
            end else if (out_free) begin
               if (sts.is_read && !sts.empty) begin
                  state_in = olpe_pkg::ST_READ;
               end else begin
                  state_in = olpe_pkg::ST_IDLE;
               end
            end
         end
         olpe_pkg::ST_READ: begin
            if (out_free && sts.rd_last) begin
               state_in = olpe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = olpe_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready      = 1'b0;
      cmd.latch       = 1'b0;
      cmd.load_status = 1'b0;
      cmd.apply_edit  = 1'b0;
      cmd.load_item   = 1'b0;
      unique case (state_ff)
         olpe_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.latch  = req_tvalid;
         end
         olpe_pkg::ST_EXEC: begin
            // a read of a non-empty list emits from the read state instead
            if (sts.valid_cmd && out_free && !(sts.is_read && !sts.empty)) begin
               cmd.load_status = 1'b1;
               cmd.apply_edit  = !sts.is_read;
            end
         end
         olpe_pkg::ST_READ: begin
            cmd.load_item = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_status || cmd.load_item) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olpe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire
